// ===== design/npk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nucleotide packer package
// Shared sizes, payload and command types, and the base coding helpers used
// by the front end, the command queue and the output sequencer.
// ----------------------------------------------------------------------------
package npk_pkg;

   // Sequence storage and word geometry.
   localparam int MAX_BASES      = 1024;
   localparam int BASES_PER_WORD = 32;
   localparam int CODE_W         = 2;
   localparam int CHAR_W         = 8;
   localparam int WORD_W         = BASES_PER_WORD * CODE_W;
   localparam int SLOT_W         = $clog2(BASES_PER_WORD);
   localparam int CNT_W          = $clog2(MAX_BASES + 1);
   localparam int ROWS           = (MAX_BASES + BASES_PER_WORD - 1) / BASES_PER_WORD;
   localparam int ROW_AW         = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SHIFT_W        = $clog2(WORD_W + 1);

   // Command queue between the front end and the output sequencer.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Character codes that carry a meaning.
   localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_1  = 8'h31;
   localparam logic [CHAR_W-1:0] CH_2  = 8'h32;
   localparam logic [CHAR_W-1:0] CH_3  = 8'h33;
   localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC = 8'h43;
   localparam logic [CHAR_W-1:0] CH_UG = 8'h47;
   localparam logic [CHAR_W-1:0] CH_UT = 8'h54;
   localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC = 8'h63;
   localparam logic [CHAR_W-1:0] CH_LG = 8'h67;
   localparam logic [CHAR_W-1:0] CH_LT = 8'h74;

   typedef struct packed {
      logic [CHAR_W-1:0] base_char;
      logic              last_base;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] packed_word;
      logic              word_last;
      logic              overflow;
   } rsp_payload_type;

   typedef enum logic {
      CMD_WORD = 1'b0,
      CMD_DUMP = 1'b1
   } cmd_kind_type;

   // A word command is sent as is; a dump command replays the stored
   // sequence backwards, total_m1 being the index of its last base.
   typedef struct packed {
      cmd_kind_type      kind;
      logic [WORD_W-1:0] word;
      logic              last;
      logic              ovf;
      logic [CNT_W-1:0]  total_m1;
   } cmd_type;

   // Two-bit code of one character in forward or reverse complement mode.
   function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] ch,
                                                   input logic rev);
      logic [CODE_W-1:0] code;
      code = '0;
      case (ch)
         CH_0:         code = 2'd0;
         CH_1:         code = 2'd1;
         CH_2:         code = 2'd2;
         CH_3:         code = 2'd3;
         CH_UA, CH_LA: code = rev ? 2'd2 : 2'd0;
         CH_UC, CH_LC: code = rev ? 2'd3 : 2'd1;
         CH_UT, CH_LT: code = rev ? 2'd0 : 2'd2;
         CH_UG, CH_LG: code = rev ? 2'd1 : 2'd3;
         default:      code = 2'd0;
      endcase
      return code;
   endfunction

   // Reverse the order of the two-bit codes in a word.
   function automatic logic [WORD_W-1:0] reverse_codes(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int k = 0; k < BASES_PER_WORD; k++) begin
         r[CODE_W*k +: CODE_W] = w[CODE_W*(BASES_PER_WORD-1-k) +: CODE_W];
      end
      return r;
   endfunction

endpackage

// ===== design/npk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module npk_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/npk_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nucleotide packer front end
// Codes each accepted base, builds the current word, writes it as a row of
// the sequence store and queues word or dump commands for the back end.
// ----------------------------------------------------------------------------
module npk_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  npk_pkg::req_payload_type       req_payload,
   input  logic                           csr_we,
   input  logic                           csr_wdata,
   output logic                           push,
   output npk_pkg::cmd_type               push_cmd,
   input  logic                           q_full,
   input  logic                           dump_done,
   output logic                           ram_wr_en,
   output logic [npk_pkg::ROW_AW-1:0]     ram_wr_addr,
   output logic [npk_pkg::WORD_W-1:0]     ram_wr_data
);

   logic                           mode_ff, mode_in;
   logic [npk_pkg::WORD_W-1:0]     acc_ff, acc_in;
   logic [npk_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                           ovf_ff, ovf_in;
   logic                           pend_ff, pend_in;

   logic                           accept;
   logic                           last;
   logic [npk_pkg::CODE_W-1:0]     code;
   logic [npk_pkg::SLOT_W-1:0]     slot;
   logic                           at_cap;
   logic                           store;
   logic                           ovf_now;
   logic                           word_full;
   logic [npk_pkg::WORD_W-1:0]     acc_new;

   // A dump in flight or a full queue holds off new beats.
   assign busy   = q_full | pend_ff;
   assign accept = start & ~busy;
   assign last   = req_payload.last_base;

   // Classify the beat: code, slot in the word, capacity check.
   assign code      = npk_pkg::base_code(req_payload.base_char, mode_ff);
   assign slot      = count_ff[npk_pkg::SLOT_W-1:0];
   assign at_cap    = (count_ff == npk_pkg::CNT_W'(npk_pkg::MAX_BASES));
   assign store     = ~ovf_ff & ~at_cap;
   assign ovf_now   = ovf_ff | at_cap;
   assign word_full = (slot == npk_pkg::SLOT_W'(npk_pkg::BASES_PER_WORD - 1));
   assign acc_new   = acc_ff | (npk_pkg::WORD_W'(code) << {slot, 1'b0});

   // The whole current word is written as the row that holds this base.
   assign ram_wr_en   = accept & store;
   assign ram_wr_addr = npk_pkg::ROW_AW'(count_ff >> npk_pkg::SLOT_W);
   assign ram_wr_data = acc_new;

   // Next sequence state and the command to queue.
   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pend_in  = pend_ff;
      push     = 1'b0;
      push_cmd = '{kind: npk_pkg::CMD_WORD, word: '0, last: 1'b0, ovf: 1'b0,
                   total_m1: '0};

      if (csr_we) begin
         mode_in = csr_wdata;
      end
      if (dump_done) begin
         pend_in = 1'b0;
      end

      if (accept) begin
         ovf_in = ovf_now;
         if (store) begin
            acc_in   = acc_new;
            count_in = count_ff + npk_pkg::CNT_W'(1);
            if (word_full && !last) begin
               acc_in = '0;
               if (!mode_ff) begin
                  push          = 1'b1;
                  push_cmd.word = acc_new;
               end
            end
         end

         if (last) begin
            push = 1'b1;
            if (ovf_now) begin
               push_cmd.last = 1'b1;
               push_cmd.ovf  = 1'b1;
            end else if (!mode_ff) begin
               push_cmd.word = acc_new;
               push_cmd.last = 1'b1;
            end else begin
               push_cmd.kind     = npk_pkg::CMD_DUMP;
               push_cmd.total_m1 = count_ff;
               pend_in           = 1'b1;
            end
            acc_in   = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   // Control and accumulator registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         acc_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ===== design/npk_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nucleotide packer command queue
// Short FIFO of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module npk_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  npk_pkg::cmd_type push_cmd,
   input  logic             pop,
   output npk_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);

   npk_pkg::cmd_type                mem_ff [npk_pkg::QUEUE_DEPTH];
   logic [npk_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [npk_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [npk_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                            do_push;
   logic                            do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == npk_pkg::QCNT_W'(npk_pkg::QUEUE_DEPTH));
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == npk_pkg::QPTR_W'(npk_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + npk_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == npk_pkg::QPTR_W'(npk_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + npk_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + npk_pkg::QCNT_W'(1);
         2'b01:   cnt_in = cnt_ff - npk_pkg::QCNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== design/npk_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nucleotide packer back end
// Sends queued words and replays a stored sequence in reverse base order,
// one output word per cycle from a row read and the row before it.
// ----------------------------------------------------------------------------
module npk_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  npk_pkg::cmd_type             q_head,
   output logic                         q_pop,
   output logic [npk_pkg::ROW_AW-1:0]   ram_rd_addr,
   input  logic [npk_pkg::WORD_W-1:0]   ram_rd_data,
   output logic                         dump_done,
   output logic                         rsp_valid,
   output npk_pkg::rsp_payload_type     rsp_payload
);

   typedef enum logic [2:0] {
      BK_IDLE   = 3'b001,
      BK_FIRST  = 3'b010,
      BK_STREAM = 3'b100
   } back_state_type;

   back_state_type                    state_ff, state_in;
   logic [npk_pkg::ROW_AW-1:0]        cur_ff, cur_in;
   logic [npk_pkg::SLOT_W-1:0]        offset_ff, offset_in;
   logic [npk_pkg::WORD_W-1:0]        hi_ff, hi_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   npk_pkg::rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   logic [npk_pkg::ROW_AW-1:0]        head_row;
   logic [npk_pkg::WORD_W-1:0]        lo;
   logic [npk_pkg::SHIFT_W-1:0]       shamt;
   logic [npk_pkg::WORD_W-1:0]        window;
   logic                              cur_zero;

   assign q_pop    = (state_ff == BK_IDLE) & ~q_empty;
   assign head_row = npk_pkg::ROW_AW'(q_head.total_m1 >> npk_pkg::SLOT_W);
   assign cur_zero = (cur_ff == '0);

   // Row below the upper one; below row zero the sequence holds nothing.
   assign lo = cur_zero ? '0 : ram_rd_data;

   // Align the 32 bases that end at the current position, then flip them.
   assign shamt  = npk_pkg::SHIFT_W'({offset_ff, 1'b0}) +
                   npk_pkg::SHIFT_W'(npk_pkg::CODE_W);
   assign window = npk_pkg::WORD_W'({hi_ff, lo} >> shamt);

   assign dump_done = (state_ff == BK_STREAM) & cur_zero;

   // Read address: first row on a dump, then one row lower every cycle.
   always_comb begin
      case (state_ff)
         BK_IDLE:   ram_rd_addr = head_row;
         BK_FIRST:  ram_rd_addr = cur_ff - npk_pkg::ROW_AW'(1);
         BK_STREAM: ram_rd_addr = cur_ff - npk_pkg::ROW_AW'(2);
         default:   ram_rd_addr = head_row;
      endcase
   end

   // Sequencer next state and output word.
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      offset_in      = offset_ff;
      hi_in          = hi_ff;
      rsp_valid_in   = 1'b0;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               if (q_head.kind == npk_pkg::CMD_WORD) begin
                  rsp_valid_in               = 1'b1;
                  rsp_payload_in.packed_word = q_head.word;
                  rsp_payload_in.word_last   = q_head.last;
                  rsp_payload_in.overflow    = q_head.ovf;
               end else begin
                  cur_in    = head_row;
                  offset_in = q_head.total_m1[npk_pkg::SLOT_W-1:0];
                  state_in  = BK_FIRST;
               end
            end
         end
         BK_FIRST: begin
            hi_in    = ram_rd_data;
            state_in = BK_STREAM;
         end
         BK_STREAM: begin
            rsp_valid_in               = 1'b1;
            rsp_payload_in.packed_word = npk_pkg::reverse_codes(window);
            rsp_payload_in.word_last   = cur_zero;
            rsp_payload_in.overflow    = 1'b0;
            hi_in                      = lo;
            cur_in                     = cur_ff - npk_pkg::ROW_AW'(1);
            if (cur_zero) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Sequencer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Row pipeline and output word.
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      offset_ff      <= offset_in;
      hi_ff          <= hi_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== design/nucleotide_2bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nucleotide 2-bit packer
// Packs ASCII bases, one per beat, into 64-bit words of 32 two-bit codes,
// forward or reverse complement.
// ----------------------------------------------------------------------------
// A base is taken at every clock edge where start is high and busy is low, so
// forward mode runs at one base per cycle; the single write port of the row
// store, written with the whole current word on every base, sets that figure.
// Each result shows on rsp_payload for exactly one cycle with rsp_valid high,
// once its command has passed the queue and the output register. The receiver
// has no way to hold results off and must take each word in the cycle it is
// shown. In reverse complement mode the final base starts a replay of
// ceil(N/32) words for N stored bases via the queue, BK_FIRST, BK_STREAM and
// the output register, one word per cycle paced by the one read port of the
// row store; busy stays high until the final word is out. No clearing pass
// follows reset. The user must write the mode register through csr_we and
// csr_wdata only while no beat is in progress; the block does not enforce it.
// ----------------------------------------------------------------------------
module nucleotide_2bit_packer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  npk_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   output npk_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_we,
   input  logic                     csr_wdata
);

   npk_pkg::cmd_type                  push_cmd;
   npk_pkg::cmd_type                  q_head;
   logic                              push;
   logic                              q_pop;
   logic                              q_empty;
   logic                              q_full;
   logic                              dump_done;
   logic                              ram_wr_en;
   logic [npk_pkg::ROW_AW-1:0]        ram_wr_addr;
   logic [npk_pkg::WORD_W-1:0]        ram_wr_data;
   logic [npk_pkg::ROW_AW-1:0]        ram_rd_addr;
   logic [npk_pkg::WORD_W-1:0]        ram_rd_data;

   // Front end: coding, word building and command issue.
   npk_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .push        (push),
      .push_cmd    (push_cmd),
      .q_full      (q_full),
      .dump_done   (dump_done),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   // Command queue between the two halves.
   npk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Sequence store, one row per 32 bases.
   npk_ram #(
      .WIDTH (npk_pkg::WORD_W),
      .DEPTH (npk_pkg::ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Back end: word output and reverse replay.
   npk_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .dump_done   (dump_done),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/npk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nucleotide packer port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module npk_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input npk_pkg::rsp_payload_type rsp_payload
);

   logic beat;

   assign beat = start & ~busy;

   // The block comes out of reset ready and silent.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or result beat right after reset");

   // An overflow result is the final, empty word of its sequence.
   a_overflow_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.overflow) |->
         (rsp_payload.word_last && rsp_payload.packed_word == '0))
      else $error("overflow result not a final zero word");

   // With no recent beat and no replay running, no result can appear.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy) && !$past(beat) && !$past(beat, 2)) |-> !rsp_valid)
      else $error("result beat without a cause");

endmodule

bind nucleotide_2bit_packer npk_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nucleotide 2-bit packer testbench
// Drives ASCII bases into the packer in bursts with random gaps. It runs
// directed checks on character coding, word boundaries, mode changes within a
// sequence and buffer overflow, then runs random sequences in both modes. A
// behavioral copy of the packer predicts every packed word, and each word
// that the block emits is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;
   import npk_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int RANDOM_ITEMS  = 130;
   // Setting this bit of an upper-case letter gives the lower-case one.
   localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_payload;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;
   logic            csr_we;
   logic            csr_wdata;

   // Behavioral state of the packer.
   logic [CODE_W-1:0] seq_codes [MAX_BASES];
   logic [WORD_W-1:0] word_acc;
   int                seq_len;
   bit                seq_overflowed;
   bit                rc_mode;

   rsp_payload_type expected_words [$];
   rsp_payload_type oldest_word;
   int              errors;
   int              cycles;
   int              burst_left;
   bit              gaps_on;

   nucleotide_2bit_packer dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   // Free-running clock with a 2 ns period.
   always #1 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Two-bit code of one character under the given mode.
   function automatic logic [CODE_W-1:0] code_of(input logic [CHAR_W-1:0] ch, input bit rc);
      logic [CODE_W-1:0] code;
      case (ch)
         CH_0:         code = 2'd0;
         CH_1:         code = 2'd1;
         CH_2:         code = 2'd2;
         CH_3:         code = 2'd3;
         CH_UA, CH_LA: code = rc ? 2'd2 : 2'd0;
         CH_UC, CH_LC: code = rc ? 2'd3 : 2'd1;
         CH_UG, CH_LG: code = rc ? 2'd1 : 2'd3;
         CH_UT, CH_LT: code = rc ? 2'd0 : 2'd2;
         default:      code = 2'd0;
      endcase
      return code;
   endfunction

   function automatic rsp_payload_type word_beat(input logic [WORD_W-1:0] w, input logic last,
                                                 input logic ovf);
      rsp_payload_type r;
      r.packed_word = w;
      r.word_last   = last;
      r.overflow    = ovf;
      return r;
   endfunction

   // Predict the words that one accepted base causes.
   function automatic void pack_base(input logic [CHAR_W-1:0] ch, input logic last);
      logic [CODE_W-1:0] code;
      logic [WORD_W-1:0] w;
      int slot;
      int pos;
      int k;
      if (!seq_overflowed) begin
         if (seq_len >= MAX_BASES) begin
            seq_overflowed = 1'b1;
         end else begin
            code = code_of(ch, rc_mode);
            slot = seq_len % BASES_PER_WORD;
            seq_codes[seq_len] = code;
            word_acc = word_acc | ({{(WORD_W-CODE_W){1'b0}}, code} << (CODE_W * slot));
            seq_len++;
            if (slot == BASES_PER_WORD - 1 && !last) begin
               if (!rc_mode) begin
                  expected_words.push_back(word_beat(word_acc, 1'b0, 1'b0));
               end
               word_acc = '0;
            end
         end
      end
      if (last) begin
         if (seq_overflowed) begin
            expected_words.push_back(word_beat('0, 1'b1, 1'b1));
         end else if (!rc_mode) begin
            expected_words.push_back(word_beat(word_acc, 1'b1, 1'b0));
         end else begin
            // Replay the whole sequence backwards, 32 codes per word.
            pos = 0;
            while (pos < seq_len) begin
               w = '0;
               for (k = 0; k < BASES_PER_WORD && pos < seq_len; k++) begin
                  w[CODE_W*k +: CODE_W] = seq_codes[seq_len - 1 - pos];
                  pos++;
               end
               expected_words.push_back(word_beat(w, pos >= seq_len, 1'b0));
            end
         end
         word_acc       = '0;
         seq_len        = 0;
         seq_overflowed = 1'b0;
      end
   endfunction

   // Check every emitted word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h last %b ovf %b", $time,
                     rsp_payload.packed_word, rsp_payload.word_last, rsp_payload.overflow);
            errors++;
         end else begin
            oldest_word = expected_words.pop_front();
            if (rsp_payload.packed_word !== oldest_word.packed_word) begin
               $display("%0t: packed_word mismatch, expected %h, actual %h", $time,
                        oldest_word.packed_word, rsp_payload.packed_word);
               errors++;
            end
            if (rsp_payload.word_last !== oldest_word.word_last) begin
               $display("%0t: word_last mismatch, expected %b, actual %b", $time,
                        oldest_word.word_last, rsp_payload.word_last);
               errors++;
            end
            if (rsp_payload.overflow !== oldest_word.overflow) begin
               $display("%0t: overflow mismatch, expected %b, actual %b", $time,
                        oldest_word.overflow, rsp_payload.overflow);
               errors++;
            end
         end
      end
   end

   // Send one base beat, with a random gap whenever a burst runs out and gaps are on.
   task automatic send_base(input logic [CHAR_W-1:0] ch, input logic last);
      req_payload_type item;
      if (gaps_on) begin
         if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      item.base_char = ch;
      item.last_base = last;
      req_payload <= item;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      pack_base(ch, last);
   endtask

   // Mostly valid letters and digits, with some arbitrary bytes mixed in.
   function automatic logic [CHAR_W-1:0] random_char();
      logic [CHAR_W-1:0] ch;
      int r;
      r = $urandom_range(0, 3);
      case ($urandom_range(0, 4))
         0: ch = CHAR_W'($urandom_range(0, 255));
         1: ch = CH_0 + CHAR_W'(r);
         default: begin
            case (r)
               0:       ch = CH_UA;
               1:       ch = CH_UC;
               2:       ch = CH_UG;
               default: ch = CH_UT;
            endcase
            if ($urandom_range(0, 1) == 1) ch = ch | CASE_BIT;
         end
      endcase
      return ch;
   endfunction

   task automatic send_random_seq(input int len, input bit close_seq);
      int i;
      for (i = 0; i < len; i++) begin
         send_base(random_char(), close_seq && (i == len - 1));
      end
   endtask

   // Hold the sender off until every expected word has come out.
   task automatic drain_results();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input bit rc);
      drain_results();
      while (busy) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= rc;
      @(posedge clock);
      csr_we  <= 1'b0;
      rc_mode = rc;
   endtask

   // Every letter in both cases, the digits and bytes outside the alphabet.
   task automatic send_corner_chars();
      logic [CHAR_W-1:0] chars [20];
      int i;
      chars = '{CH_UA, CH_UC, CH_UG, CH_UT, CH_LA, CH_LC, CH_LG, CH_LT,
                CH_0, CH_1, CH_2, CH_3, 8'h00, 8'hFF, 8'h80, 8'h7F,
                8'h42, 8'h55, 8'h34, 8'h2F};
      for (i = 0; i < 20; i++) begin
         send_base(chars[i], i == 19);
      end
      send_base(CH_UG, 1'b1);
   endtask

   task automatic test_corner_chars_forward();
      set_mode(1'b0);
      send_corner_chars();
   endtask

   task automatic test_corner_chars_reverse();
      set_mode(1'b1);
      send_corner_chars();
   endtask

   // Sequences that end on and just after a word boundary, and one of two full words.
   task automatic test_word_boundaries();
      set_mode(1'b0);
      send_random_seq(32, 1'b1);
      send_random_seq(33, 1'b1);
      send_random_seq(64, 1'b1);
      set_mode(1'b1);
      send_random_seq(32, 1'b1);
      send_random_seq(33, 1'b1);
   endtask

   // The mode flips inside an open sequence; the mode at the end decides its output form.
   task automatic test_mode_switch();
      set_mode(1'b0);
      send_random_seq(40, 1'b0);
      set_mode(1'b1);
      send_random_seq(10, 1'b1);
      send_random_seq(10, 1'b0);
      set_mode(1'b0);
      send_random_seq(5, 1'b1);
   endtask

   // A full buffer, then sequences past capacity in both modes.
   task automatic test_capacity();
      gaps_on = 1'b0;
      set_mode(1'b1);
      send_random_seq(MAX_BASES, 1'b1);
      set_mode(1'b0);
      send_random_seq(MAX_BASES + 1, 1'b1);
      set_mode(1'b1);
      send_random_seq(MAX_BASES + 6, 1'b1);
      gaps_on = 1'b1;
   endtask

   task automatic test_random_sequences();
      int sent;
      int len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            set_mode(1'($urandom_range(0, 1)));
         end else if ($urandom_range(0, 5) == 0) begin
            drain_results();
         end
         gaps_on = ($urandom_range(0, 4) != 0);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 96) : $urandom_range(1, 40);
         send_random_seq(len, 1'b1);
         sent += len;
      end
   endtask

   // Reset, the test sequence and the final verdict.
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_payload    = '0;
      csr_we         = 1'b0;
      csr_wdata      = 1'b0;
      word_acc       = '0;
      seq_len        = 0;
      seq_overflowed = 1'b0;
      rc_mode        = 1'b0;
      errors         = 0;
      cycles         = 0;
      burst_left     = 0;
      gaps_on        = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_chars_forward();
      test_corner_chars_reverse();
      test_word_boundaries();
      test_mode_switch();
      test_capacity();
      test_random_sequences();
      drain_results();

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== nucleotide_2bit_packer.f =====
design/npk_pkg.sv
design/npk_ram.sv
design/npk_front.sv
design/npk_queue.sv
design/npk_back.sv
design/nucleotide_2bit_packer.sv
design/npk_checker.sv
tb/tb.sv
